// File: rtl/coverage_run_length_core_defines.svh
// Assertion helpers shared by the coverage run-length RTL.
`ifndef COVERAGE_RUN_LENGTH_CORE_DEFINES_SVH
`define COVERAGE_RUN_LENGTH_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define CVR_ASSERT_HOLDS(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define CVR_ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
    else $error(msg);

`endif

// File: rtl/cvr_pkg.sv
`timescale 1ns / 1ps
package cvr_pkg;

  // Fixed field widths of the channels
  localparam int POS_W   = 17;
  localparam int START_W = 16;
  localparam int VAL_W   = 16;

  // Defaults for the top-level parameters
  localparam int MAX_POSITIONS_DEF = 65536;
  localparam int COUNT_BITS_DEF    = 16;

  // chrom_size after reset
  localparam logic [POS_W-1:0] CHROM_SIZE_RST = 17'h10000;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Classified command: fetch, or add over [lo, hi) with hi already clamped
  typedef struct packed {
    logic               fetch;
    logic [START_W-1:0] lo;
    logic [POS_W-1:0]   hi;
  } cvr_cmd_t;

endpackage

// File: rtl/cvr_if.sv
`timescale 1ns / 1ps

// Input item channel
interface cvr_item_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [cvr_pkg::START_W-1:0] interval_start;
  logic [cvr_pkg::POS_W-1:0]   interval_end;

  modport source (output valid, func, interval_start, interval_end, input ready);
  modport sink   (input valid, func, interval_start, interval_end, output ready);
endinterface

// Result run channel
interface cvr_run_if;
  logic                        valid;
  logic                        ready;
  logic [cvr_pkg::START_W-1:0] run_position;
  logic [cvr_pkg::POS_W-1:0]   run_span;
  logic [cvr_pkg::VAL_W-1:0]   run_value;
  logic                        last_run;

  modport source (output valid, run_position, run_span, run_value, last_run, input ready);
  modport sink   (input valid, run_position, run_span, run_value, last_run, output ready);
endinterface

// File: rtl/cvr_ram.sv
`timescale 1ns / 1ps
module cvr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/cvr_front.sv
`timescale 1ns / 1ps
module cvr_front (
  input  logic                      clk,
  input  logic                      rst_n,
  cvr_item_if.sink                  in_ch,
  input  logic [cvr_pkg::POS_W-1:0] act_size,
  input  logic                      clearing,
  input  logic                      q_full,
  output logic                      q_push,
  output cvr_pkg::cvr_cmd_t         q_cmd
);

  logic                      cmd_vld_r, cmd_vld_nxt;
  cvr_pkg::cvr_cmd_t         cmd_r, cmd_nxt;
  logic                      take;
  logic                      keep;
  logic [cvr_pkg::POS_W-1:0] hi_clamp;

  // Hold off while the store is being cleared or the stage cannot drain
  assign in_ch.ready = !clearing && (!cmd_vld_r || !q_full);
  assign take        = in_ch.valid && in_ch.ready;

  // Clamp the interval end to the active size; empty adds are dropped here
  assign hi_clamp = (in_ch.interval_end > act_size) ? act_size : in_ch.interval_end;
  assign keep     = in_ch.func ||
                    (hi_clamp > cvr_pkg::POS_W'(in_ch.interval_start));

  assign q_push = cmd_vld_r && !q_full;
  assign q_cmd  = cmd_r;

  always_comb begin
    cmd_vld_nxt = cmd_vld_r;
    cmd_nxt     = cmd_r;
    if (q_push) begin
      cmd_vld_nxt = 1'b0;
    end
    if (take) begin
      cmd_vld_nxt   = keep;
      cmd_nxt.fetch = in_ch.func;
      cmd_nxt.lo    = in_ch.interval_start;
      cmd_nxt.hi    = hi_clamp;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
    end else begin
      cmd_vld_r <= cmd_vld_nxt;
    end
  end

endmodule

// File: rtl/cvr_queue.sv
`timescale 1ns / 1ps
`include "coverage_run_length_core_defines.svh"
module cvr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cvr_pkg::cvr_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output cvr_pkg::cvr_cmd_t pop_cmd,
  output logic              empty
);

  localparam int QA_W  = (cvr_pkg::QUEUE_DEPTH > 1) ? $clog2(cvr_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(cvr_pkg::QUEUE_DEPTH + 1);

  cvr_pkg::cvr_cmd_t slot_r [cvr_pkg::QUEUE_DEPTH];
  logic [QA_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QA_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  function automatic logic [QA_W-1:0] ptr_inc(input logic [QA_W-1:0] p);
    ptr_inc = (p == QA_W'(cvr_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (cnt_r == CNT_W'(cvr_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = slot_r[rd_ptr_r];

  // Pointer and fill-count update
  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `CVR_ASSERT_NEVER(a_no_push_full, clk, rst_n, push && full, "command pushed into full queue")
  `CVR_ASSERT_NEVER(a_no_pop_empty, clk, rst_n, pop && empty, "command popped from empty queue")

endmodule

// File: rtl/cvr_back.sv
`timescale 1ns / 1ps
`include "coverage_run_length_core_defines.svh"
module cvr_back #(
  parameter int MAX_POSITIONS = cvr_pkg::MAX_POSITIONS_DEF,
  parameter int COUNT_BITS    = cvr_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [cvr_pkg::POS_W-1:0] act_size,
  input  logic                      q_empty,
  input  cvr_pkg::cvr_cmd_t         q_cmd,
  output logic                      q_pop,
  output logic                      clearing,
  cvr_run_if.source                 out_ch
);

  localparam int ADDR_W = $clog2(MAX_POSITIONS);
  localparam int POS_W  = cvr_pkg::POS_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_ADD, ST_FETCH} state_t;

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]           clr_addr_r, clr_addr_nxt;
  logic [POS_W-1:0]            rd_pos_r, rd_pos_nxt;
  logic [POS_W-1:0]            chk_pos_r, chk_pos_nxt;
  logic                        chk_vld_r, chk_vld_nxt;
  logic [POS_W-1:0]            hi_r, hi_nxt;
  logic [POS_W-1:0]            cursor_r, cursor_nxt;
  logic [POS_W-1:0]            run_pos_r, run_pos_nxt;
  logic [POS_W-1:0]            span_r, span_nxt;
  logic                        first_r, first_nxt;
  logic [COUNT_BITS-1:0]       val_r, val_nxt;

  logic                        out_vld_r, out_vld_nxt;
  logic [cvr_pkg::START_W-1:0] out_pos_r, out_pos_nxt;
  logic [POS_W-1:0]            out_span_r, out_span_nxt;
  logic [cvr_pkg::VAL_W-1:0]   out_val_r, out_val_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        ram_we, ram_re;
  logic [ADDR_W-1:0]           ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0]       ram_wdata, ram_rdata;

  logic [POS_W-1:0]            start_pos;
  logic [POS_W-1:0]            chk_inc;
  logic [POS_W-1:0]            span_inc;
  logic                        match;
  logic [COUNT_BITS-1:0]       cur_val;

  cvr_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (MAX_POSITIONS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign clearing = (state_r == ST_CLEAR);

  // A cursor left beyond a shrunk size restarts the read-out at zero
  assign start_pos = (cursor_r >= act_size) ? '0 : cursor_r;
  assign chk_inc   = chk_pos_r + 1'b1;
  assign span_inc  = span_r + 1'b1;
  assign match     = first_r || (ram_rdata == val_r);
  assign cur_val   = first_r ? ram_rdata : val_r;

  assign out_ch.valid        = out_vld_r;
  assign out_ch.run_position = out_pos_r;
  assign out_ch.run_span     = out_span_r;
  assign out_ch.run_value    = out_val_r;
  assign out_ch.last_run     = out_last_r;

  // Sequencer: read one position per cycle in ST_ADD and ST_FETCH, write back the entry returned by the previous read
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    rd_pos_nxt   = rd_pos_r;
    chk_pos_nxt  = chk_pos_r;
    chk_vld_nxt  = chk_vld_r;
    hi_nxt       = hi_r;
    cursor_nxt   = cursor_r;
    run_pos_nxt  = run_pos_r;
    span_nxt     = span_r;
    first_nxt    = first_r;
    val_nxt      = val_r;
    out_vld_nxt  = out_vld_r;
    out_pos_nxt  = out_pos_r;
    out_span_nxt = out_span_r;
    out_val_nxt  = out_val_r;
    out_last_nxt = out_last_r;
    ram_we       = 1'b0;
    ram_waddr    = ADDR_W'(chk_pos_r);
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = ADDR_W'(rd_pos_r);
    q_pop        = 1'b0;

    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        if (clr_addr_r == ADDR_W'(MAX_POSITIONS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (!q_empty) begin
          if (!q_cmd.fetch) begin
            q_pop       = 1'b1;
            rd_pos_nxt  = POS_W'(q_cmd.lo);
            hi_nxt      = q_cmd.hi;
            chk_vld_nxt = 1'b0;
            state_nxt   = ST_ADD;
          end else if (!out_vld_r || out_ch.ready) begin
            // Output slot is free by the time this run completes
            q_pop       = 1'b1;
            rd_pos_nxt  = start_pos;
            run_pos_nxt = start_pos;
            span_nxt    = '0;
            first_nxt   = 1'b1;
            chk_vld_nxt = 1'b0;
            state_nxt   = ST_FETCH;
          end
        end
      end

      ST_ADD: begin
        // Saturating increment of the entry returned by the previous read
        if (chk_vld_r) begin
          ram_we    = 1'b1;
          ram_wdata = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;
        end
        if (rd_pos_r < hi_r) begin
          ram_re      = 1'b1;
          chk_pos_nxt = rd_pos_r;
          chk_vld_nxt = 1'b1;
          rd_pos_nxt  = rd_pos_r + 1'b1;
        end else begin
          chk_vld_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end

      ST_FETCH: begin
        if (rd_pos_r < act_size) begin
          ram_re      = 1'b1;
          chk_pos_nxt = rd_pos_r;
          chk_vld_nxt = 1'b1;
          rd_pos_nxt  = rd_pos_r + 1'b1;
        end else begin
          chk_vld_nxt = 1'b0;
        end
        if (chk_vld_r) begin
          first_nxt = 1'b0;
          val_nxt   = cur_val;
          if (match) begin
            // Entry joins the run and is cleared
            ram_we    = 1'b1;
            ram_wdata = '0;
            span_nxt  = span_inc;
            if (chk_inc >= act_size) begin
              out_vld_nxt  = 1'b1;
              out_pos_nxt  = cvr_pkg::START_W'(run_pos_r);
              out_span_nxt = span_inc;
              out_val_nxt  = cvr_pkg::VAL_W'(cur_val);
              out_last_nxt = 1'b1;
              cursor_nxt   = '0;
              chk_vld_nxt  = 1'b0;
              state_nxt    = ST_IDLE;
            end
          end else begin
            // Value changed: run ends before this entry, which stays untouched
            out_vld_nxt  = 1'b1;
            out_pos_nxt  = cvr_pkg::START_W'(run_pos_r);
            out_span_nxt = span_r;
            out_val_nxt  = cvr_pkg::VAL_W'(cur_val);
            out_last_nxt = 1'b0;
            cursor_nxt   = chk_pos_r;
            chk_vld_nxt  = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_pos_r   <= rd_pos_nxt;
    chk_pos_r  <= chk_pos_nxt;
    hi_r       <= hi_nxt;
    run_pos_r  <= run_pos_nxt;
    span_r     <= span_nxt;
    first_r    <= first_nxt;
    val_r      <= val_nxt;
    out_pos_r  <= out_pos_nxt;
    out_span_r <= out_span_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      chk_vld_r  <= 1'b0;
      cursor_r   <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      chk_vld_r  <= chk_vld_nxt;
      cursor_r   <= cursor_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  `CVR_ASSERT_HOLDS(a_out_from_fetch, clk, rst_n, $rose(out_vld_r) |-> $past(state_r) == ST_FETCH, "run presented outside a fetch")
  `CVR_ASSERT_NEVER(a_span_nonzero, clk, rst_n, out_vld_r && (out_span_r == '0), "run with zero span")
  `CVR_ASSERT_HOLDS(a_add_in_range, clk, rst_n, (state_r == ST_ADD) && ram_we |-> chk_pos_r < hi_r, "add writes beyond interval end")

endmodule

// File: rtl/coverage_run_length_core.sv
// Coverage run-length core. An item with func 0 adds one to every position in
// [interval_start, interval_end), clipped to chrom_size, with counts saturating;
// it gives no result. An item with func 1 returns the next run of equal counts
// from the read-out cursor (zero runs included), clears the scanned entries and
// flags the run that reaches chrom_size as last_run, after which the cursor
// restarts at zero. After reset the store is cleared one entry per cycle; no item
// is taken in that time, but chrom_size may be written. The store has one read and
// one write port and the back end visits one position per cycle; empty adds are
// dropped in the front end. A two-entry command queue and a result register let
// new items be taken while a run waits on out_ch. Write chrom_size only when the
// block is idle.
`timescale 1ns / 1ps
module coverage_run_length_core #(
  parameter int MAX_POSITIONS = cvr_pkg::MAX_POSITIONS_DEF,
  parameter int COUNT_BITS    = cvr_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  cvr_item_if.sink                  in_ch,
  cvr_run_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [cvr_pkg::POS_W-1:0] cfg_wdata
);

  logic [cvr_pkg::POS_W-1:0] chrom_size_r, chrom_size_nxt;
  logic [cvr_pkg::POS_W-1:0] act_size;
  logic                      clearing;
  logic                      q_push, q_full, q_pop, q_empty;
  cvr_pkg::cvr_cmd_t         q_cmd_in, q_cmd_out;

  // Configuration register
  assign chrom_size_nxt = cfg_we ? cfg_wdata : chrom_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chrom_size_r <= cvr_pkg::CHROM_SIZE_RST;
    end else begin
      chrom_size_r <= chrom_size_nxt;
    end
  end

  // Active size: chrom_size clamped to 1 .. MAX_POSITIONS
  always_comb begin
    if (chrom_size_r == '0) begin
      act_size = cvr_pkg::POS_W'(1);
    end else if (32'(chrom_size_r) > 32'(MAX_POSITIONS)) begin
      act_size = cvr_pkg::POS_W'(MAX_POSITIONS);
    end else begin
      act_size = chrom_size_r;
    end
  end

  cvr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .act_size (act_size),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd_in)
  );

  cvr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_cmd_out),
    .empty    (q_empty)
  );

  cvr_back #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .act_size (act_size),
    .q_empty  (q_empty),
    .q_cmd    (q_cmd_out),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule

// File: sim/coverage_run_length_checker.sv
`timescale 1ns / 1ps

// Watches the item and run channels and the chrom_size port. Keeps its own
// coverage map and read-out cursor, predicts each run when its fetch transfers
// in, and compares every run transfer field by field with the oldest prediction.
module coverage_run_length_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  cvr_item_if                       item_mon,
  cvr_run_if                        run_mon,
  input  logic                      cfg_we,
  input  logic [cvr_pkg::POS_W-1:0] cfg_wdata,
  output int unsigned               mismatches,
  output int unsigned               runs_pending,
  output int unsigned               adds_seen,
  output int unsigned               runs_seen,
  output int unsigned               final_runs,
  output int unsigned               zero_runs,
  output int unsigned               saturated_runs,
  output int unsigned               restarted_scans
);

  localparam int unsigned MAP_DEPTH = cvr_pkg::MAX_POSITIONS_DEF;
  localparam int          CNT_W     = cvr_pkg::COUNT_BITS_DEF;
  localparam int          START_W   = cvr_pkg::START_W;
  localparam int          POS_W     = cvr_pkg::POS_W;
  localparam int          VAL_W     = cvr_pkg::VAL_W;
  localparam logic [CNT_W-1:0] COUNT_SAT = '1;

  typedef struct packed {
    logic [START_W-1:0] position;
    logic [POS_W-1:0]   span;
    logic [VAL_W-1:0]   value;
    logic               last;
  } run_t;

  logic [CNT_W-1:0] cov_map [MAP_DEPTH];
  logic [POS_W-1:0] size_reg;
  int unsigned      scan_pos;
  run_t             runs_due [$];
  int unsigned      n_fail, n_adds, n_runs, n_final, n_zero, n_sat, n_restart;

  // chrom_size clamped to 1..MAP_DEPTH
  function automatic int unsigned active_positions();
    int unsigned n;
    n = 32'(size_reg);
    if (n == 0) n = 1;
    if (n > MAP_DEPTH) n = MAP_DEPTH;
    return n;
  endfunction

  // One interval: +1 on [lo, hi), clipped to the active size, saturating
  task automatic add_interval(input int unsigned lo, input int unsigned hi);
    int unsigned stop;
    stop = (hi > active_positions()) ? active_positions() : hi;
    for (int unsigned p = lo; p < stop; p++) begin
      if (cov_map[p] != COUNT_SAT) cov_map[p] = cov_map[p] + 1'b1;
    end
  endtask

  // Next run from the cursor; scanned entries are cleared
  task automatic next_run(output run_t r);
    int unsigned      n, first, p;
    logic [CNT_W-1:0] val;
    n = active_positions();
    first = scan_pos;
    // cursor left beyond a shrunk map: start over at zero
    if (first >= n) begin
      first = 0;
      n_restart++;
    end
    val = cov_map[first];
    p = first;
    while (p < n && cov_map[p] == val) begin
      cov_map[p] = '0;
      p++;
    end
    r.position = first[START_W-1:0];
    r.span     = POS_W'(p - first);
    r.value    = VAL_W'(val);
    r.last     = (p >= n);
    scan_pos   = r.last ? 0 : p;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    n_fail++;
  endtask

  always @(posedge clk) begin
    run_t want;
    if (!rst_n) begin
      foreach (cov_map[i]) cov_map[i] = '0;
      size_reg = cvr_pkg::CHROM_SIZE_RST;
      scan_pos = 0;
      runs_due.delete();
      n_fail = 0; n_adds = 0; n_runs = 0; n_final = 0;
      n_zero = 0; n_sat = 0; n_restart = 0;
    end else begin
      if (cfg_we) size_reg = cfg_wdata;

      // item transfer: update the map or queue the predicted run
      if (item_mon.valid && item_mon.ready) begin
        if (item_mon.func) begin
          next_run(want);
          runs_due = {runs_due, want};
        end else begin
          add_interval(32'(item_mon.interval_start), 32'(item_mon.interval_end));
          n_adds++;
        end
      end

      // run transfer: compare with the oldest prediction
      if (run_mon.valid && run_mon.ready) begin
        if (runs_due.size() == 0) begin
          report_mismatch("run with no fetch pending, run_position",
                          32'(run_mon.run_position), '0);
        end else begin
          want = runs_due.pop_front();
          if (run_mon.run_position !== want.position)
            report_mismatch($sformatf("run %0d run_position", n_runs),
                            32'(run_mon.run_position), 32'(want.position));
          if (run_mon.run_span !== want.span)
            report_mismatch($sformatf("run %0d run_span", n_runs),
                            32'(run_mon.run_span), 32'(want.span));
          if (run_mon.run_value !== want.value)
            report_mismatch($sformatf("run %0d run_value", n_runs),
                            32'(run_mon.run_value), 32'(want.value));
          if (run_mon.last_run !== want.last)
            report_mismatch($sformatf("run %0d last_run", n_runs),
                            32'(run_mon.last_run), 32'(want.last));
          if (want.last) n_final++;
          if (want.value == '0) n_zero++;
          if (want.value == VAL_W'(COUNT_SAT)) n_sat++;
        end
        n_runs++;
      end
    end

    mismatches      <= n_fail;
    runs_pending    <= runs_due.size();
    adds_seen       <= n_adds;
    runs_seen       <= n_runs;
    final_runs      <= n_final;
    zero_runs       <= n_zero;
    saturated_runs  <= n_sat;
    restarted_scans <= n_restart;
  end

endmodule

// File: sim/tb_coverage_run_length_core.sv
`timescale 1ns / 1ps

module tb_coverage_run_length_core;

  localparam int unsigned HOLD_CYCLES  = 500;
  localparam int unsigned QUIET_LIMIT  = 1000000;
  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned STACK_ADDS   = 20;
  localparam int unsigned MAP_DEPTH    = cvr_pkg::MAX_POSITIONS_DEF;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [cvr_pkg::POS_W-1:0] cfg_wdata;

  cvr_item_if item_ch ();
  cvr_run_if  run_ch ();

  int unsigned mismatches, runs_pending, adds_seen, runs_seen;
  int unsigned final_runs, zero_runs, saturated_runs, restarted_scans;

  // stimulus-side view of the block
  int unsigned cur_size;
  int unsigned add_backlog;
  int unsigned sizes_set;
  bit          hold_req;
  bit          hold_active;

  coverage_run_length_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (item_ch),
    .out_ch    (run_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  coverage_run_length_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_mon        (item_ch),
    .run_mon         (run_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .runs_pending    (runs_pending),
    .adds_seen       (adds_seen),
    .runs_seen       (runs_seen),
    .final_runs      (final_runs),
    .zero_runs       (zero_runs),
    .saturated_runs  (saturated_runs),
    .restarted_scans (restarted_scans)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long
  task automatic pick_gap(output int unsigned g);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) g = 0;
    else if (r < 88) g = $urandom_range(1, 3);
    else if (r < 97) g = $urandom_range(4, 15);
    else g = $urandom_range(30, 120);
  endtask

  // One item transfer; valid stays high afterwards so back-to-back items flow
  task automatic send_item(input bit fn, input int unsigned lo, input int unsigned hi,
                           input bit use_gaps);
    int unsigned gap, stop;
    gap = 0;
    if (use_gaps) pick_gap(gap);
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid          <= 1'b1;
    item_ch.func           <= fn;
    item_ch.interval_start <= lo[cvr_pkg::START_W-1:0];
    item_ch.interval_end   <= hi[cvr_pkg::POS_W-1:0];
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    // work still in flight behind the last run; a fetch drains everything before it
    if (fn) begin
      add_backlog = 0;
    end else begin
      stop = (hi > cur_size) ? cur_size : hi;
      add_backlog += (stop > lo) ? stop - lo + 3 : 1;
    end
  endtask

  // Stop offering, wait for every run, then let pending adds finish
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (runs_pending != 0) @(posedge clk);
    repeat (add_backlog + 16) @(posedge clk);
    add_backlog = 0;
  endtask

  task automatic write_size(input int unsigned v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v[cvr_pkg::POS_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_size = (v == 0) ? 1 : ((v > MAP_DEPTH) ? MAP_DEPTH : v);
    sizes_set++;
  endtask

  // Run receiver: random ready with bursts, plus a long hold-off on request
  initial begin
    int unsigned on_len, gap;
    run_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        run_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
      end
      run_ch.ready <= 1'b1;
      on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 12);
      repeat (on_len) @(posedge clk);
      pick_gap(gap);
      if (gap != 0) begin
        run_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run after too long without any transfer
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (run_ch.valid && run_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("FAIL coverage_run_length_core");
    $finish;
  end

  initial begin
    int unsigned r, lo, hi, n_items, done_items, big_phases;
    bit          fn;

    rst_n                  <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_wdata              <= '0;
    item_ch.valid          <= 1'b0;
    item_ch.func           <= 1'b0;
    item_ch.interval_start <= '0;
    item_ch.interval_end   <= '0;
    cur_size    = MAP_DEPTH;
    add_backlog = 0;
    sizes_set   = 0;
    hold_req    = 1'b0;
    hold_active = 1'b0;
    done_items  = 0;
    big_phases  = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes on the full map (the block clears its store first)
    send_item(0, 65535, 65536, 1);
    send_item(0, 0, 65536, 1);
    send_item(0, 65534, 131071, 1);
    send_item(0, 100, 50, 1);
    send_item(0, 7, 7, 1);
    send_item(1, 0, 0, 1);
    send_item(1, 65535, 131071, 1);
    send_item(1, 0, 0, 1);

    // Shrink in mid read-out, then grow back over the stale entries
    write_size(16);
    send_item(0, 0, 4, 1);
    send_item(0, 2, 10, 1);
    send_item(0, 12, 16, 1);
    send_item(1, 0, 0, 1);
    send_item(1, 0, 0, 1);
    write_size(2);
    send_item(1, 0, 0, 1);
    write_size(16);
    send_item(1, 0, 0, 1);
    send_item(1, 0, 0, 1);

    // Size zero behaves as one position; oversize behaves as the full map
    write_size(0);
    send_item(0, 0, 5, 1);
    send_item(1, 0, 0, 1);
    write_size(131071);
    send_item(1, 0, 0, 1);
    send_item(1, 0, 0, 1);
    send_item(1, 0, 0, 1);

    // Stack many adds on one position back to back, then read the map out
    write_size(8);
    send_item(0, 0, 2, 0);
    repeat (STACK_ADDS) send_item(0, 2, 3, 0);
    send_item(0, 1, 4, 0);
    repeat (5) send_item(1, $urandom_range(0, 65535), $urandom_range(0, 131071), 1);

    // Receiver holds off while fetches keep coming, so the input backs up
    write_size($urandom_range(24, 48));
    repeat (6) begin
      lo = $urandom_range(0, cur_size - 1);
      send_item(0, lo, lo + $urandom_range(1, 8), 1);
    end
    item_ch.valid <= 1'b0;
    hold_req = 1'b1;
    do @(posedge clk); while (!hold_active);
    repeat (24) send_item(1, $urandom, $urandom, 0);

    // Random phases, each under a new chrom_size
    while (done_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      n_items = $urandom_range(30, 80);
      if (r < 45) write_size($urandom_range(1, 16));
      else if (r < 75) write_size($urandom_range(17, 200));
      else if (r < 90) write_size($urandom_range(201, 3000));
      else if (r < 95) write_size($urandom_range(0, 1));
      else if (big_phases == 0) begin
        big_phases++;
        n_items = 10;
        write_size(($urandom_range(0, 1) != 0) ? MAP_DEPTH : $urandom_range(65537, 131071));
      end else write_size($urandom_range(2, 8));

      repeat (n_items) begin
        r  = $urandom_range(0, 99);
        fn = 1'b0;
        lo = $urandom_range(0, 65535);
        hi = $urandom_range(0, 131071);
        if (r < 45) begin
          fn = 1'b1;
        end else if (r < 85) begin
          // interval inside the map, may run past its end
          lo = $urandom_range(0, cur_size - 1);
          hi = lo + $urandom_range(1, (cur_size <= 512) ? cur_size : 64);
        end else if (r < 93) begin
          hi = $urandom_range(0, lo);
        end else if (cur_size > 4096 && hi > lo + 64) begin
          // keep wide noise intervals off the big maps
          hi = lo;
        end
        send_item(fn, lo, hi, 1);
        done_items++;
      end
    end

    wait_idle();
    $display("Covered %0d interval adds and %0d checked runs: %0d final, %0d zero,",
             adds_seen, runs_seen, final_runs, zero_runs);
    $display("%0d saturated, %0d chrom_size settings, %0d restarted scans, %0d mismatches",
             saturated_runs, sizes_set, restarted_scans, mismatches);
    if (mismatches == 0 && runs_pending == 0) begin
      $display("PASS coverage_run_length_core");
    end else begin
      $display("FAIL coverage_run_length_core");
    end
    $finish;
  end

endmodule
